/* rtl/mftt_pkg.sv */
// ----------------------------------------------------------------------------
// mftt_pkg
// shared types and constants of the motor feedback turn tracker
// ----------------------------------------------------------------------------
package mftt_pkg;

    localparam int MOTOR_SLOTS_DEF = 8;
    localparam logic [10:0] BASE_ID_RST = 11'h201;
    localparam int JUMP_LIMIT = 4095;
    // 8192 counts per turn
    localparam int TURN_SHIFT = 13;

    localparam int PADDR_W = 3;
    localparam logic REG_BASE_ID = 1'b0;

    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] angle;
        logic [15:0] speed;
        logic [15:0] current;
        logic [7:0]  temp;
        logic [31:0] turns;
    } row_t;

    typedef struct packed {
        row_t        row;
        logic        first;
        logic [31:0] total;
    } upd_t;

    localparam row_t ROW_CLEAR = '0;

endpackage

/* rtl/mftt_store.sv */
// ----------------------------------------------------------------------------
// mftt_store
// per-motor entry memory with registered read and seen flags
// ----------------------------------------------------------------------------
module mftt_store #(
    parameter int MOTOR_SLOTS = 8,
    parameter int SLOT_W      = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output mftt_pkg::row_t    rd_row,
    output logic              rd_seen,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  mftt_pkg::row_t    wr_row
);
    import mftt_pkg::*;

    row_t                   mem [MOTOR_SLOTS];
    row_t                   rd_data_reg;
    logic                   rd_seen_reg;
    logic [MOTOR_SLOTS-1:0] seen_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            rd_seen_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                seen_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_seen_reg <= seen_reg[rd_addr];
            end
        end
    end

    // entries never written since reset read as zero
    assign rd_row  = rd_seen_reg ? rd_data_reg : ROW_CLEAR;
    assign rd_seen = rd_seen_reg;

endmodule

/* rtl/mftt_update.sv */
// ----------------------------------------------------------------------------
// mftt_update
// entry update: offset capture, angle unwrap and total angle
// ----------------------------------------------------------------------------
module mftt_update (
    input  logic           seen,
    input  mftt_pkg::row_t cur,
    input  logic [15:0]    angle,
    input  logic [15:0]    speed,
    input  logic [15:0]    current,
    input  logic [7:0]     temp,
    output mftt_pkg::upd_t res
);
    import mftt_pkg::*;

    logic signed [16:0] diff;
    logic [31:0]        turns_dec;
    logic [31:0]        turns_inc;
    row_t               row;

    always_comb begin
        diff      = $signed({1'b0, angle}) - $signed({1'b0, cur.angle});
        turns_dec = cur.turns - 32'd1;
        turns_inc = cur.turns + 32'd1;
        row       = cur;
        row.angle = angle;
        if (!seen) begin
            row.offset = angle;
        end else begin
            row.speed   = speed;
            row.current = current;
            row.temp    = temp;
            if (diff > $signed(17'(JUMP_LIMIT))) begin
                row.turns = turns_dec;
            end else if (diff < -$signed(17'(JUMP_LIMIT))) begin
                row.turns = turns_inc;
            end
        end
        res.row   = row;
        res.first = !seen;
        res.total = {row.turns[31-TURN_SHIFT:0], TURN_SHIFT'(0)}
                  + {16'd0, row.angle} - {16'd0, row.offset};
    end

endmodule

/* rtl/motor_feedback_turn_tracker.sv */
// ----------------------------------------------------------------------------
// motor_feedback_turn_tracker
// multi-turn rotor angle tracking for a window of motor feedback frames
// ----------------------------------------------------------------------------
// flow: frame registered on accept, entry updated in ST_CALC when m side is free
// no new frame is taken in ST_CALC, which follows the read of the entry memory
//   ahead of its read-modify-write
// frames outside the window are accepted in ST_IDLE and give no result
// reset: synchronous, all entries read as zero at once, base_id back to 0x201
module motor_feedback_turn_tracker #(
    parameter int MOTOR_SLOTS = mftt_pkg::MOTOR_SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mftt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [10:0]                  s_frame_id,
    input  logic [63:0]                  s_payload,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_motor_slot,
    output logic                         m_first_frame,
    output logic [15:0]                  m_rotor_angle,
    output logic signed [15:0]           m_rotor_speed,
    output logic signed [15:0]           m_drive_current,
    output logic [7:0]                   m_temperature,
    output logic signed [31:0]           m_turn_count,
    output logic signed [31:0]           m_unwrapped_angle
);
    import mftt_pkg::*;

    localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
    localparam int IDX_W  = (SLOT_W > 3) ? SLOT_W : 3;

    typedef enum logic {ST_IDLE, ST_CALC} state_t;

    state_t            state_reg;
    logic [10:0]       base_id_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [55:0]       frame_data_reg;
    logic              m_valid_reg;
    logic [2:0]        m_slot_reg;
    logic              m_first_reg;
    logic [15:0]       m_angle_reg;
    logic [15:0]       m_speed_reg;
    logic [15:0]       m_current_reg;
    logic [7:0]        m_temp_reg;
    logic [31:0]       m_turns_reg;
    logic [31:0]       m_total_reg;

    logic [11:0]       id_diff;
    logic              in_window;
    logic              s_accept;
    logic              out_free;
    logic              rd_en;
    logic              wr_en;
    logic              rd_seen;
    row_t              rd_row;
    upd_t              upd;
    logic              cfg_sel;

    // configuration
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1:2] == REG_BASE_ID);
    assign prdata  = cfg_sel ? {21'd0, base_id_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_id_reg <= BASE_ID_RST;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            base_id_reg <= pwdata[10:0];
        end
    end

    // identifier window, no wrap past the top
    assign id_diff   = {1'b0, s_frame_id} - {1'b0, base_id_reg};
    assign in_window = !id_diff[11] && (id_diff[10:0] < 11'(MOTOR_SLOTS));

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = s_accept && in_window;
    assign wr_en    = (state_reg == ST_CALC) && out_free;

    mftt_store #(
        .MOTOR_SLOTS (MOTOR_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (id_diff[SLOT_W-1:0]),
        .rd_row  (rd_row),
        .rd_seen (rd_seen),
        .wr_en   (wr_en),
        .wr_addr (slot_reg[SLOT_W-1:0]),
        .wr_row  (upd.row)
    );

    mftt_update u_update (
        .seen    (rd_seen),
        .cur     (rd_row),
        .angle   (frame_data_reg[55:40]),
        .speed   (frame_data_reg[39:24]),
        .current (frame_data_reg[23:8]),
        .temp    (frame_data_reg[7:0]),
        .res     (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (rd_en) begin
                        slot_reg       <= id_diff[IDX_W-1:0];
                        frame_data_reg <= s_payload[63:8];
                        state_reg      <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    if (out_free) begin
                        m_slot_reg    <= slot_reg[2:0];
                        m_first_reg   <= upd.first;
                        m_angle_reg   <= upd.row.angle;
                        m_speed_reg   <= upd.row.speed;
                        m_current_reg <= upd.row.current;
                        m_temp_reg    <= upd.row.temp;
                        m_turns_reg   <= upd.row.turns;
                        m_total_reg   <= upd.total;
                        state_reg     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_motor_slot      = m_slot_reg;
    assign m_first_frame     = m_first_reg;
    assign m_rotor_angle     = m_angle_reg;
    assign m_rotor_speed     = $signed(m_speed_reg);
    assign m_drive_current   = $signed(m_current_reg);
    assign m_temperature     = m_temp_reg;
    assign m_turn_count      = $signed(m_turns_reg);
    assign m_unwrapped_angle = $signed(m_total_reg);

    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_first_reg |-> m_total_reg == 32'd0 && m_turns_reg == 32'd0)
        else $error("first transaction of an entry with nonzero turns or total");

    a_wr_loads_out: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("entry write without result transaction");

    a_read_to_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |=> state_reg == ST_CALC && !s_ready)
        else $error("entry read not followed by update");

endmodule
